// ----- src/tla_pkg.sv -----
// Shared codes, types and helper functions of the toroidal life block.
`default_nettype none

package tla_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_LIFE   = 2'd1;
  localparam logic [1:0] MODE_FILL   = 2'd2;
  localparam logic [1:0] MODE_BATTLE = 2'd3;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_GREEN = 2'd1;
  localparam logic [1:0] KIND_RED   = 2'd2;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_SEED   = 2'd3;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // 3x3 window slots, row major: top row 0..2, middle 3..5, bottom 6..8
  localparam logic [3:0] SLOT_FIRST    = 4'd0;
  localparam logic [3:0] SLOT_CENTER   = 4'd4;
  localparam logic [3:0] SLOT_LAST_ROW = 4'd6;
  localparam logic [3:0] SLOT_COUNT    = 4'd9;

  typedef logic [8:0][1:0] cell_win_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] lfsr;
  } rule_out_t;

  function automatic logic [15:0] lfsr_adv(input logic [15:0] v);
    lfsr_adv = (v >> 1) ^ (v[0] ? LFSR_TAPS : 16'h0000);
  endfunction

  function automatic logic [1:0] kind_of(input logic [1:0] k);
    kind_of = (k == 2'd3) ? KIND_RED : k;
  endfunction

  function automatic logic [1:0] slot_row(input logic [3:0] s);
    case (s)
      4'd0, 4'd1, 4'd2: slot_row = 2'd0;
      4'd3, 4'd4, 4'd5: slot_row = 2'd1;
      default:          slot_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] slot_col(input logic [3:0] s);
    case (s)
      4'd0, 4'd3, 4'd6: slot_col = 2'd0;
      4'd1, 4'd4, 4'd7: slot_col = 2'd1;
      default:          slot_col = 2'd2;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/tla_cell_mem.sv -----
// Cell memory: one write port, two registered read ports.
`default_nettype none

module tla_cell_mem #(
  parameter int AW = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [1:0]    wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [1:0]    rdata_a,
  output logic      [1:0]    rdata_b
);

  logic [1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- src/tla_rule_eval.sv -----
// Next-kind evaluation of one cell from its 3x3 window, with LFSR draws.
`default_nettype none

module tla_rule_eval (
  input  wire logic [1:0]         mode,
  input  wire tla_pkg::cell_win_t win,
  input  wire logic [15:0]        lfsr,
  output tla_pkg::rule_out_t      res
);

  logic [3:0]  n;
  logic [3:0]  green;
  logic [3:0]  red;
  logic [1:0]  cur;
  logic [15:0] l1;
  logic        born;

  always_comb begin
    n     = 4'd0;
    green = 4'd0;
    red   = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        if (win[i] != tla_pkg::KIND_EMPTY) n = n + 4'd1;
        if (win[i] == tla_pkg::KIND_GREEN) green = green + 4'd1;
        if (win[i] == tla_pkg::KIND_RED)   red = red + 4'd1;
      end
    end
  end

  always_comb begin
    cur      = win[tla_pkg::SLOT_CENTER];
    // first draw only when exactly four neighbors are live
    l1       = (n == 4'd4) ? tla_pkg::lfsr_adv(lfsr) : lfsr;
    born     = (n == 4'd3) || ((n == 4'd4) && (lfsr[1:0] == 2'b00));
    res.kind = cur;
    res.lfsr = lfsr;
    if (mode == tla_pkg::MODE_BATTLE) begin
      if (cur != tla_pkg::KIND_EMPTY) begin
        res.kind = (n == 4'd2 || n == 4'd3) ? cur : tla_pkg::KIND_EMPTY;
      end else begin
        res.lfsr = l1;
        if (born) begin
          if (green > red) begin
            res.kind = tla_pkg::KIND_GREEN;
          end else if (red > green) begin
            res.kind = tla_pkg::KIND_RED;
          end else begin
            res.kind = l1[0] ? tla_pkg::KIND_RED : tla_pkg::KIND_GREEN;
            res.lfsr = tla_pkg::lfsr_adv(l1);
          end
        end
      end
    end else if (cur == tla_pkg::KIND_GREEN) begin
      res.kind = (n == 4'd2 || n == 4'd3) ? tla_pkg::KIND_GREEN : tla_pkg::KIND_EMPTY;
    end else if (mode == tla_pkg::MODE_FILL) begin
      if (n == 4'd1) res.kind = tla_pkg::KIND_RED;
    end else begin
      if (n == 4'd3) res.kind = tla_pkg::KIND_GREEN;
    end
  end

endmodule

`default_nettype wire

// ----- src/toroidal_life_automaton_core.sv -----
// Top level: channels, configuration, step/clear sequencer and cell memory.
// Toroidal cellular automaton on a MAX_WIDTH x MAX_HEIGHT grid of 2-bit cells.
// Input channel (in_valid/in_ready): operation, column, row, cell_kind.
// Output channel (out_valid/out_ready): read_kind, write_ignored; exactly one
// transfer per input transfer, in order.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// rule_mode, active_width, active_height or random_seed; write only while idle.
// A write answers from ST_DONE, a read after the registered memory read
// (ST_RD_WAIT); a clear sweeps all MAX_WIDTH*MAX_HEIGHT cells; a step's time
// is set by the 3x3 window fetch through the two memory read ports (three
// new cells per cell down a column, nine at a column top).
// The grid lives in two memory banks; a step reads one and writes the other,
// then swaps them. Mode 0 steps change nothing and go straight to ST_DONE.
// A new input is taken while a finished result waits on out_ready; the next
// result then holds in the engine until the output register frees.
// Reset: a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells zeroes the active
// bank; in_ready stays low meanwhile. Config writes are taken as usual.
`default_nettype none

module toroidal_life_automaton_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [5:0]  column,
  input  wire logic [5:0]  row,
  input  wire logic [1:0]  cell_kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  read_kind,
  output logic             write_ignored,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RH = $clog2(MAX_HEIGHT);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = 1 + RH + CW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_FETCH, ST_WAIT, ST_EVAL, ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [1:0] rule_mode;
  logic [6:0] active_width;
  logic [6:0] active_height;
  logic       cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode     <= tla_pkg::MODE_LIFE;
      active_width  <= 7'd64;
      active_height <= 7'd64;
    end else if (cfg_fire) begin
      case (cfg_index)
        tla_pkg::CFG_MODE:   rule_mode     <= cfg_data[1:0];
        tla_pkg::CFG_WIDTH:  active_width  <= cfg_data[6:0];
        tla_pkg::CFG_HEIGHT: active_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // effective window size: zero counts as one, clipped to the grid
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [XW-1:0] w_m1;
  logic [YW-1:0] h_m1;

  always_comb begin
    if (active_width == 7'd0)                 w_eff = XW'(1);
    else if (int'(active_width) > MAX_WIDTH)  w_eff = XW'(MAX_WIDTH);
    else                                      w_eff = XW'(active_width);
    if (active_height == 7'd0)                h_eff = YW'(1);
    else if (int'(active_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else                                      h_eff = YW'(active_height);
    w_m1 = w_eff - XW'(1);
    h_m1 = h_eff - YW'(1);
  end

  // sweep position and window
  logic [CW-1:0]      x;
  logic [RH-1:0]      y;
  logic               bank;
  logic [3:0]         k;
  logic [3:0]         k_end;
  tla_pkg::cell_win_t win;
  logic               cap_a_v;
  logic               cap_b_v;
  logic [3:0]         cap_a_k;
  logic [3:0]         cap_b_k;
  logic [1:0]         clr_kind;
  logic               clr_reply;
  logic [15:0]        lfsr;
  logic [1:0]         res_kind;
  logic               res_ign;

  logic          in_fire;
  logic          in_inside;
  logic          cell_in;
  logic          y_last;
  logic          last_cell;
  logic [CW-1:0] nx;
  logic [RH-1:0] ny;
  logic          n_inside;
  logic [3:0]    n_k;
  logic [3:0]    n_k_end;
  logic [CW-1:0] xm1;
  logic [CW-1:0] xp1;
  logic [RH-1:0] ym1;
  logic [RH-1:0] yp1;
  logic [CW-1:0] cols [3];
  logic [RH-1:0] rows [3];
  logic [3:0]    kb;
  logic          b_live;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign in_inside = (11'(column) < 11'(w_eff)) && (11'(row) < 11'(h_eff));
  assign cell_in   = (XW'(x) < w_eff) && (YW'(y) < h_eff);
  assign y_last    = (y == RH'(MAX_HEIGHT - 1));
  assign last_cell = y_last && (x == CW'(MAX_WIDTH - 1));
  assign nx        = y_last ? x + CW'(1) : x;
  assign ny        = y_last ? '0 : y + RH'(1);
  assign n_inside  = (XW'(nx) < w_eff) && (YW'(ny) < h_eff);
  // column top fetches all nine, further rows the bottom three, outside cells
  // only the center (a plain copy)
  assign n_k       = !n_inside ? tla_pkg::SLOT_CENTER :
                     (ny == '0) ? tla_pkg::SLOT_FIRST : tla_pkg::SLOT_LAST_ROW;
  assign n_k_end   = n_inside ? tla_pkg::SLOT_COUNT : tla_pkg::SLOT_CENTER + 4'd1;

  assign xm1     = (x == '0) ? CW'(w_m1) : x - CW'(1);
  assign xp1     = (XW'(x) == w_m1) ? '0 : x + CW'(1);
  assign ym1     = (y == '0) ? RH'(h_m1) : y - RH'(1);
  assign yp1     = (YW'(y) == h_m1) ? '0 : y + RH'(1);
  assign cols[0] = xm1;
  assign cols[1] = x;
  assign cols[2] = xp1;
  assign rows[0] = ym1;
  assign rows[1] = y;
  assign rows[2] = yp1;
  assign kb      = k + 4'd1;
  assign b_live  = (kb < k_end);

  // memory and rule evaluation
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [1:0]    rdata_a;
  logic [1:0]    rdata_b;
  tla_pkg::rule_out_t rule;

  tla_cell_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  tla_rule_eval u_rule (
    .mode (rule_mode),
    .win  (win),
    .lfsr (lfsr),
    .res  (rule)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bank, RH'(row), CW'(column)};
    mem_wdata = tla_pkg::kind_of(cell_kind);
    raddr_a   = {bank, RH'(row), CW'(column)};
    raddr_b   = {bank, rows[tla_pkg::slot_row(kb)], cols[tla_pkg::slot_col(kb)]};
    case (state)
      ST_IDLE: begin
        mem_we = in_fire && (operation == tla_pkg::OP_WRITE) && in_inside;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {bank, y, x};
        mem_wdata = clr_kind;
      end
      ST_FETCH: begin
        raddr_a = {bank, rows[tla_pkg::slot_row(k)], cols[tla_pkg::slot_col(k)]};
      end
      ST_EVAL: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank, y, x};
        mem_wdata = cell_in ? rule.kind : win[tla_pkg::SLOT_CENTER];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      x         <= '0;
      y         <= '0;
      bank      <= 1'b0;
      clr_kind  <= tla_pkg::KIND_EMPTY;
      clr_reply <= 1'b0;
      cap_a_v   <= 1'b0;
      cap_b_v   <= 1'b0;
      out_valid <= 1'b0;
      lfsr      <= 16'd1;
    end else begin
      cap_a_v <= 1'b0;
      cap_b_v <= 1'b0;
      // ST_DONE reloads the output register itself
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      if (cap_a_v) win[cap_a_k] <= rdata_a;
      if (cap_b_v) win[cap_b_k] <= rdata_b;

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            res_kind <= tla_pkg::KIND_EMPTY;
            res_ign  <= (operation == tla_pkg::OP_WRITE) && !in_inside;
            x        <= '0;
            y        <= '0;
            k        <= tla_pkg::SLOT_FIRST;
            k_end    <= tla_pkg::SLOT_COUNT;
            case (operation)
              tla_pkg::OP_WRITE: state <= ST_DONE;
              tla_pkg::OP_READ:  state <= in_inside ? ST_RD_WAIT : ST_DONE;
              tla_pkg::OP_STEP: begin
                state <= (rule_mode != tla_pkg::MODE_OFF) ? ST_FETCH : ST_DONE;
              end
              default: begin
                clr_kind  <= tla_pkg::kind_of(cell_kind);
                clr_reply <= 1'b1;
                state     <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_kind <= rdata_a;
          state    <= ST_DONE;
        end
        ST_CLEAR: begin
          x <= nx;
          y <= ny;
          if (last_cell) begin
            res_kind <= tla_pkg::KIND_EMPTY;
            res_ign  <= 1'b0;
            state    <= clr_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_FETCH: begin
          cap_a_v <= 1'b1;
          cap_a_k <= k;
          cap_b_v <= b_live;
          cap_b_k <= kb;
          k       <= k + 4'd2;
          if (k + 4'd2 >= k_end) state <= ST_WAIT;
        end
        ST_WAIT: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          // slide the window down one row for the next cell of this column
          win[2:0] <= win[5:3];
          win[5:3] <= win[8:6];
          if (last_cell) begin
            bank     <= ~bank;
            res_kind <= tla_pkg::KIND_EMPTY;
            res_ign  <= 1'b0;
            state    <= ST_DONE;
          end else begin
            x     <= nx;
            y     <= ny;
            k     <= n_k;
            k_end <= n_k_end;
            state <= ST_FETCH;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            read_kind     <= res_kind;
            write_ignored <= res_ign;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_fire && cfg_index == tla_pkg::CFG_SEED) begin
        lfsr <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      end else if (state == ST_EVAL && cell_in) begin
        lfsr <= rule.lfsr;
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tla_checker.sv -----
// Checker: watches all three channels, keeps its own grid model and compares results.
`timescale 1ns / 100ps

module tla_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [5:0]  column,
  input  wire logic [5:0]  row,
  input  wire logic [1:0]  cell_kind,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  read_kind,
  input  wire logic        write_ignored,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               errors,
  output int               pending
);

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;

  typedef struct {
    logic [1:0] kind;
    logic       ignored;
  } answer_t;

  logic [1:0]  grid      [0:GRID_W*GRID_H-1];
  logic [1:0]  grid_next [0:GRID_W*GRID_H-1];
  logic [1:0]  mode;
  logic [6:0]  wid;
  logic [6:0]  hei;
  logic [15:0] lfsr;
  answer_t     answers[$];

  initial errors = 0;

  function automatic int eff_size(input logic [6:0] v, input int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic logic [1:0] stored_kind(input logic [1:0] k);
    return (k == 2'd3) ? tla_pkg::KIND_RED : k;
  endfunction

  function automatic logic [15:0] pull_random();
    logic [15:0] v;
    v = lfsr;
    lfsr = (lfsr >> 1) ^ (lfsr[0] ? tla_pkg::LFSR_TAPS : 16'h0000);
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic advance_generation();
    int w, h, n, greens, reds, pos;
    logic [1:0] cur, v;
    logic born;
    w = eff_size(wid, GRID_W);
    h = eff_size(hei, GRID_H);
    if (mode == tla_pkg::MODE_OFF) return;
    grid_next = grid;
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        n = 0; greens = 0; reds = 0;
        pos = y * GRID_W + x;
        cur = grid[pos];
        for (int dy = 0; dy < 3; dy++) begin
          for (int dx = 0; dx < 3; dx++) begin
            if (dx == 1 && dy == 1) continue;
            v = grid[((y + dy + h - 1) % h) * GRID_W + ((x + dx + w - 1) % w)];
            if (v != tla_pkg::KIND_EMPTY) n++;
            if (v == tla_pkg::KIND_GREEN) greens++;
            else if (v == tla_pkg::KIND_RED) reds++;
          end
        end
        if (mode != tla_pkg::MODE_BATTLE) begin
          if (cur == tla_pkg::KIND_GREEN) begin
            if (n < 2 || n > 3) grid_next[pos] = tla_pkg::KIND_EMPTY;
          end else if (mode == tla_pkg::MODE_LIFE) begin
            if (n == 3) grid_next[pos] = tla_pkg::KIND_GREEN;
          end else if (n == 1) begin
            grid_next[pos] = tla_pkg::KIND_RED;
          end
        end else if (cur != tla_pkg::KIND_EMPTY) begin
          if (n < 2 || n > 3) grid_next[pos] = tla_pkg::KIND_EMPTY;
        end else begin
          born = (n == 3);
          if (n == 4) born = (pull_random() & 16'h3) == 0;
          if (born) begin
            if (greens > reds) grid_next[pos] = tla_pkg::KIND_GREEN;
            else if (reds > greens) grid_next[pos] = tla_pkg::KIND_RED;
            else grid_next[pos] = pull_random() & 16'h1 ? tla_pkg::KIND_RED
                                                        : tla_pkg::KIND_GREEN;
          end
        end
      end
    end
    grid = grid_next;
  endtask

  always @(posedge clk) begin
    answer_t a, got;
    int w, h;
    logic in_win;
    if (rst) begin
      foreach (grid[i]) grid[i] = tla_pkg::KIND_EMPTY;
      mode = tla_pkg::MODE_LIFE; wid = 7'd64; hei = 7'd64; lfsr = 16'd1;
      answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tla_pkg::CFG_MODE:   mode = cfg_data[1:0];
          tla_pkg::CFG_WIDTH:  wid = cfg_data[6:0];
          tla_pkg::CFG_HEIGHT: hei = cfg_data[6:0];
          tla_pkg::CFG_SEED:   lfsr = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          a = answers.pop_front();
          if (read_kind !== a.kind)
            flag_mismatch($sformatf("read_kind %0d, want %0d", read_kind, a.kind));
          if (write_ignored !== a.ignored)
            flag_mismatch($sformatf("write_ignored %0b, want %0b", write_ignored, a.ignored));
        end
      end
      if (in_valid && in_ready) begin
        w = eff_size(wid, GRID_W);
        h = eff_size(hei, GRID_H);
        in_win = (column < w) && (row < h);
        got.kind = tla_pkg::KIND_EMPTY;
        got.ignored = 1'b0;
        case (operation)
          tla_pkg::OP_WRITE: begin
            if (in_win) grid[row * GRID_W + column] = stored_kind(cell_kind);
            else got.ignored = 1'b1;
          end
          tla_pkg::OP_READ: if (in_win) got.kind = grid[row * GRID_W + column];
          tla_pkg::OP_STEP: advance_generation();
          default: foreach (grid[i]) grid[i] = stored_kind(cell_kind);
        endcase
        answers = {answers, got};
      end
    end
    pending <= answers.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top: drives stimulus into the life core and gives the verdict.
`timescale 1ns / 100ps

module tb;

  // cycles with no transfer anywhere before we call it hung; chosen to leave a
  // wide margin over a full-size step
  localparam int HANG_LIMIT = 100000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = tla_pkg::OP_READ;
  logic [5:0]  column = '0;
  logic [5:0]  row = '0;
  logic [1:0]  cell_kind = tla_pkg::KIND_EMPTY;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  read_kind;
  logic        write_ignored;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = tla_pkg::CFG_MODE;
  logic [15:0] cfg_data = '0;

  int errors, pending;
  bit calm = 1'b0;     // no idling on either side while set
  int stall_left = 0;
  int quiet_cycles = 0;

  // current effective window, used to aim random cells
  int win_w = 64, win_h = 64;

  always #5 clk = ~clk;

  toroidal_life_automaton_core dut (
    .clk, .rst, .in_valid, .in_ready, .operation, .column, .row, .cell_kind,
    .out_valid, .out_ready, .read_kind, .write_ignored,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tla_checker chk (
    .clk, .rst, .in_valid, .in_ready, .operation, .column, .row, .cell_kind,
    .out_valid, .out_ready, .read_kind, .write_ignored,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // Result side: random stall bursts on out_ready unless calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any transfer restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Every task below starts and ends just after a rising edge.
  task automatic send_item(input logic [1:0] op, input logic [5:0] c,
                           input logic [5:0] r, input logic [1:0] k);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    column <= c;
    row <= r;
    cell_kind <= k;
    // in_ready only moves on rising edges, so the falling edge is a safe look
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  // Hold the sender until the block has answered everything.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [1:0] m, input logic [6:0] w, input logic [6:0] h,
                            input logic [15:0] seed);
    write_reg(tla_pkg::CFG_MODE, {14'd0, m});
    write_reg(tla_pkg::CFG_WIDTH, {9'd0, w});
    write_reg(tla_pkg::CFG_HEIGHT, {9'd0, h});
    write_reg(tla_pkg::CFG_SEED, seed);
    win_w = (w == 0) ? 1 : (w > 64 ? 64 : w);
    win_h = (h == 0) ? 1 : (h > 64 ? 64 : h);
  endtask

  // Mostly writes and reads inside the window so that steps have live
  // patterns to chew on; some stray coordinates and a few clears.
  task automatic random_item();
    int p;
    logic [5:0] c, r;
    p = $urandom_range(0, 99);
    c = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, win_w - 1));
    r = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, win_h - 1));
    if (p < 55) send_item(tla_pkg::OP_WRITE, c, r, 2'($urandom));
    else if (p < 82) send_item(tla_pkg::OP_READ, c, r, 2'($urandom));
    else if (p < 96) send_item(tla_pkg::OP_STEP, c, r, 2'($urandom));
    else send_item(tla_pkg::OP_CLEAR, c, r,
                   ($urandom_range(0, 1) == 0) ? tla_pkg::KIND_EMPTY : 2'($urandom));
  endtask

  logic [1:0]  ph_mode [8] = '{tla_pkg::MODE_BATTLE, tla_pkg::MODE_FILL, tla_pkg::MODE_LIFE,
                               tla_pkg::MODE_OFF, tla_pkg::MODE_BATTLE, tla_pkg::MODE_BATTLE,
                               tla_pkg::MODE_LIFE, tla_pkg::MODE_FILL};
  logic [6:0]  ph_w    [8] = '{7'd4, 7'd5, 7'd0, 7'd8, 7'd127, 7'd3, 7'd6, 7'd64};
  logic [6:0]  ph_h    [8] = '{7'd4, 7'd3, 7'd127, 7'd8, 7'd2, 7'd3, 7'd7, 7'd64};
  logic [15:0] ph_seed [8] = '{16'd0, 16'hFFFF, 16'd123, 16'd1, 16'hACE1, 16'h8001,
                               16'h0F0F, 16'h5555};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: 64x64, life, seed 1.
    send_item(tla_pkg::OP_WRITE, 6'd0, 6'd0, tla_pkg::KIND_GREEN);
    send_item(tla_pkg::OP_WRITE, 6'd63, 6'd63, tla_pkg::KIND_RED);
    send_item(tla_pkg::OP_WRITE, 6'd63, 6'd0, 2'd3);      // kind three stores red
    send_item(tla_pkg::OP_READ, 6'd63, 6'd0, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_READ, 6'd0, 6'd0, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_READ, 6'd63, 6'd63, tla_pkg::KIND_EMPTY);
    // vertical blinker, flips to horizontal
    send_item(tla_pkg::OP_WRITE, 6'd10, 6'd5, tla_pkg::KIND_GREEN);
    send_item(tla_pkg::OP_WRITE, 6'd10, 6'd6, tla_pkg::KIND_GREEN);
    send_item(tla_pkg::OP_WRITE, 6'd10, 6'd7, tla_pkg::KIND_GREEN);
    send_item(tla_pkg::OP_STEP, 6'd0, 6'd0, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_READ, 6'd9, 6'd6, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_READ, 6'd10, 6'd5, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_READ, 6'd0, 6'd63, tla_pkg::KIND_EMPTY);  // wrapped corners
    send_item(tla_pkg::OP_CLEAR, 6'd0, 6'd0, 2'd3);
    send_item(tla_pkg::OP_READ, 6'd42, 6'd21, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_CLEAR, 6'd0, 6'd0, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_READ, 6'd42, 6'd21, tla_pkg::KIND_EMPTY);
    drain();

    // Tiny window: writes and reads outside are refused; clear reaches all.
    set_window(tla_pkg::MODE_LIFE, 7'd2, 7'd2, 16'd7);
    send_item(tla_pkg::OP_WRITE, 6'd5, 6'd1, tla_pkg::KIND_GREEN);
    send_item(tla_pkg::OP_WRITE, 6'd1, 6'd63, tla_pkg::KIND_RED);
    send_item(tla_pkg::OP_READ, 6'd1, 6'd5, tla_pkg::KIND_EMPTY);
    send_item(tla_pkg::OP_CLEAR, 6'd0, 6'd0, tla_pkg::KIND_GREEN);
    send_item(tla_pkg::OP_STEP, 6'd0, 6'd0, tla_pkg::KIND_EMPTY);  // self-wrap counting
    send_item(tla_pkg::OP_READ, 6'd1, 6'd1, tla_pkg::KIND_EMPTY);
    drain();

    // Random phases over several settings, extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      set_window(ph_mode[ph], ph_w[ph], ph_h[ph], ph_seed[ph]);
      calm = (ph == 2) || (ph == 7);
      // clear once so the big window does not drag a stale pattern around
      if (ph == 7) send_item(tla_pkg::OP_CLEAR, 6'd0, 6'd0, tla_pkg::KIND_EMPTY);
      for (int i = 0; i < ((ph == 7) ? 10 : 15); i++) random_item();
      drain();
    end

    // wait out anything left, with a bound
    for (int i = 0; i < 200000 && pending != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
